/* rtl/bmsi_pkg.sv */
// Shared types and constants for the bank mapper with scanline IRQ.
// No dependencies; imported by bmsi_xlate and bank_mapper_with_scanline_irq.
package bmsi_pkg;

  localparam int NUM_BANK_REGS = 11;

  typedef enum logic [1:0] {
    ACT_CPU_WRITE = 2'd0,
    ACT_TICK      = 2'd1,
    ACT_CHR_FETCH = 2'd2,
    ACT_PRG_FETCH = 2'd3
  } action_t;

  // CPU register decode (address AND DECODE_MASK)
  localparam logic [15:0] DECODE_MASK   = 16'hF001;
  localparam logic [15:0] REG_COMMAND   = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA = 16'h8001;
  localparam logic [15:0] REG_MIRROR    = 16'hA000;
  localparam logic [15:0] REG_IRQ_LATCH = 16'hC000;
  localparam logic [15:0] REG_IRQ_RLOAD = 16'hC001;
  localparam logic [15:0] REG_IRQ_OFF   = 16'hE000;
  localparam logic [15:0] REG_IRQ_ON    = 16'hE001;

  // Configuration register indexes
  localparam logic [7:0] CFG_CHR_MASK = 8'd0;
  localparam logic [7:0] CFG_PRG_MASK = 8'd1;

  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
  localparam logic [3:0] CMD_IDX_ALT_PRG   = 4'hF;
  localparam logic [3:0] BANK_ALT_PRG      = 4'd10;

  typedef logic [NUM_BANK_REGS-1:0][7:0] bank_array_t;

  // Mode bits the translator needs from the command byte
  typedef struct packed {
    logic banks_loaded;
    logic chr_invert;   // command bit 7
    logic chr_fine;     // command bit 5: 1K mode for low slots
    logic prg_swap;     // command bit 6
  } map_ctrl_t;

endpackage

/* rtl/bmsi_xlate.sv */
// Fetch address to bank page translation for CHR and PRG fetches.
// Depends on bmsi_pkg (bank_array_t, map_ctrl_t, bank indexes).
module bmsi_xlate (
  input  logic                 is_prg,
  input  logic [15:0]          address,
  input  bmsi_pkg::map_ctrl_t  ctrl,
  input  bmsi_pkg::bank_array_t banks,
  input  logic [7:0]           chr_page_mask,
  input  logic [7:0]           prg_page_mask,
  output logic [7:0]           page
);
  import bmsi_pkg::*;

  logic [2:0] chr_slot;
  logic [1:0] prg_slot;
  logic [3:0] sel;
  logic       pair_mode;
  logic [7:0] raw;
  logic [7:0] bank_q;

  assign chr_slot = address[12:10] ^ {ctrl.chr_invert, 2'b00};
  assign prg_slot = address[14:13];

  // Pick one bank register for this fetch
  always_comb begin
    sel       = 4'd0;
    pair_mode = 1'b0;
    if (is_prg) begin
      if (prg_slot == 2'd1) begin
        sel = 4'd7;
      end else if ((prg_slot == 2'd0) != ctrl.prg_swap) begin
        sel = 4'd6;
      end else begin
        sel = BANK_ALT_PRG;
      end
    end else if (!chr_slot[2]) begin
      if (ctrl.chr_fine) begin
        case (chr_slot[1:0])
          2'd0:    sel = 4'd0;
          2'd1:    sel = 4'd8;
          2'd2:    sel = 4'd1;
          default: sel = 4'd9;
        endcase
      end else begin
        sel       = {3'd0, chr_slot[1]};
        pair_mode = 1'b1;
      end
    end else begin
      sel = {1'b0, chr_slot} - 4'd2;
    end
  end

  assign bank_q = banks[sel];
  assign raw    = pair_mode ? {bank_q[7:1], chr_slot[0]} : bank_q;

  always_comb begin
    if (is_prg) begin
      if (!ctrl.banks_loaded || prg_slot == 2'd3) begin
        page = prg_page_mask;
      end else begin
        page = raw & prg_page_mask;
      end
    end else begin
      if (!ctrl.banks_loaded) begin
        page = {5'd0, address[12:10]} & chr_page_mask;
      end else begin
        page = raw & chr_page_mask;
      end
    end
  end

endmodule

/* rtl/bank_mapper_with_scanline_irq.sv */
// Top level of the bank mapper with scanline / cycle IRQ counter.
// Depends on bmsi_pkg and bmsi_xlate.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one word per bus event:
//   a CPU register write, a scanline tick, a CHR fetch or a PRG fetch.
//   Output channel (out_valid / out_ready) returns exactly one word per
//   input word: the translated page (zero for writes and ticks), the IRQ
//   pulse raised by a tick, and the mirroring in effect after the event.
//   Configuration port (cfg_we / cfg_index / cfg_data) sets the CHR and
//   PRG page masks; write it only while no word is in flight.
// Output timing and throughput:
//   out_valid rises in the cycle after acceptance. Mapper state is updated on the
//   accepting edge and the result lands in a single output register, so a
//   word is taken every cycle while the output register drains (out_ready high).
// Reset (rst_n low, synchronous): command byte, IRQ state and mirroring
//   clear, all bank registers go to 0xFF, both masks go to 0xFF, and the
//   output register empties.
// Stall: while out_ready is low with a result held, in_ready drops; the
//   held result and all mapper state stay put until the result is taken.
module bank_mapper_with_scanline_irq #(
  parameter int CYCLES_PER_LINE_DIV4 = 28
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [8:0]  in_scanline,
  input  logic        in_rendering_enabled,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_page,
  output logic        out_irq_request,
  output logic        out_mirror_horizontal,
  // configuration port
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import bmsi_pkg::*;

  localparam logic [7:0] LINE_STEP = 8'(CYCLES_PER_LINE_DIV4);

  // mapper state
  logic [7:0]  chr_mask_r, prg_mask_r;
  logic [7:0]  command_r, command_nxt;
  bank_array_t banks_r, banks_nxt;
  logic        loaded_r, loaded_nxt;
  logic [7:0]  latch_r, latch_nxt;
  logic [7:0]  counter_r, counter_nxt;
  logic        irq_en_r, irq_en_nxt;
  logic        reload_r, reload_nxt;
  logic        cycle_mode_r, cycle_mode_nxt;
  logic        mirror_r, mirror_nxt;

  // result register
  logic        out_valid_r;
  logic [7:0]  page_r;
  logic        irq_r;
  logic        mirror_out_r;

  logic        accept;
  action_t     action;
  logic [15:0] reg_addr;
  logic [3:0]  bank_idx;
  logic [7:0]  dec_count;
  logic        irq_nxt;
  logic [7:0]  fetch_page;
  logic [7:0]  page_nxt;
  map_ctrl_t   ctrl;

  // Take a new word whenever the output slot is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign action   = action_t'(in_action);
  assign reg_addr = in_address & DECODE_MASK;
  assign bank_idx = command_r[3:0];
  assign dec_count = counter_r - 8'd1;

  assign ctrl.banks_loaded = loaded_r;
  assign ctrl.chr_invert   = command_r[7];
  assign ctrl.chr_fine     = command_r[5];
  assign ctrl.prg_swap     = command_r[6];

  bmsi_xlate u_xlate (
    .is_prg        (action == ACT_PRG_FETCH),
    .address       (in_address),
    .ctrl          (ctrl),
    .banks         (banks_r),
    .chr_page_mask (chr_mask_r),
    .prg_page_mask (prg_mask_r),
    .page          (fetch_page)
  );

  // Next state for the accepted word
  always_comb begin
    command_nxt    = command_r;
    banks_nxt      = banks_r;
    loaded_nxt     = loaded_r;
    latch_nxt      = latch_r;
    counter_nxt    = counter_r;
    irq_en_nxt     = irq_en_r;
    reload_nxt     = reload_r;
    cycle_mode_nxt = cycle_mode_r;
    mirror_nxt     = mirror_r;
    irq_nxt        = 1'b0;
    page_nxt       = 8'd0;
    case (action)
      ACT_CPU_WRITE: begin
        case (reg_addr)
          REG_COMMAND: command_nxt = in_data;
          REG_BANK_DATA: begin
            // indexes 10..14 select nothing; 15 is the alternate PRG bank
            if (bank_idx < BANK_ALT_PRG) begin
              banks_nxt[bank_idx] = in_data;
            end else if (bank_idx == CMD_IDX_ALT_PRG) begin
              banks_nxt[BANK_ALT_PRG] = in_data;
            end
            loaded_nxt = 1'b1;
          end
          REG_MIRROR: mirror_nxt = in_data[0];
          REG_IRQ_LATCH: begin
            latch_nxt = in_data;
            if (reload_r) begin
              counter_nxt = in_data;
            end
          end
          REG_IRQ_RLOAD: begin
            reload_nxt     = 1'b1;
            counter_nxt    = latch_r;
            cycle_mode_nxt = in_data[0];
          end
          REG_IRQ_OFF, REG_IRQ_ON: begin
            irq_en_nxt = in_address[0];
            if (reload_r) begin
              counter_nxt = latch_r;
            end
          end
          default: ;
        endcase
      end
      ACT_TICK: begin
        if (cycle_mode_r) begin
          // subtract one line's worth; wrap to 0xFF below a full step
          if (counter_r < LINE_STEP) begin
            counter_nxt = 8'hFF;
            irq_nxt     = irq_en_r;
          end else begin
            counter_nxt = counter_r - LINE_STEP;
          end
        end else if (in_scanline <= LAST_VISIBLE_LINE && in_rendering_enabled) begin
          reload_nxt  = 1'b0;
          counter_nxt = dec_count;
          if (dec_count == 8'hFF && irq_en_r) begin
            reload_nxt = 1'b1;
            irq_nxt    = 1'b1;
          end
        end
      end
      ACT_CHR_FETCH, ACT_PRG_FETCH: page_nxt = fetch_page;
      default: ;
    endcase
  end

  // Mapper state: advance only on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_r    <= '0;
      banks_r      <= {NUM_BANK_REGS{8'hFF}};
      loaded_r     <= 1'b0;
      latch_r      <= '0;
      counter_r    <= '0;
      irq_en_r     <= 1'b0;
      reload_r     <= 1'b0;
      cycle_mode_r <= 1'b0;
      mirror_r     <= 1'b0;
    end else if (accept) begin
      command_r    <= command_nxt;
      banks_r      <= banks_nxt;
      loaded_r     <= loaded_nxt;
      latch_r      <= latch_nxt;
      counter_r    <= counter_nxt;
      irq_en_r     <= irq_en_nxt;
      reload_r     <= reload_nxt;
      cycle_mode_r <= cycle_mode_nxt;
      mirror_r     <= mirror_nxt;
    end
  end

  // Page masks; writes to unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chr_mask_r <= 8'hFF;
      prg_mask_r <= 8'hFF;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CHR_MASK) begin
        chr_mask_r <= cfg_data;
      end else if (cfg_index == CFG_PRG_MASK) begin
        prg_mask_r <= cfg_data;
      end
    end
  end

  // Result register: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page_r       <= page_nxt;
      irq_r        <= irq_nxt;
      mirror_out_r <= mirror_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_page              = page_r;
  assign out_irq_request       = irq_r;
  assign out_mirror_horizontal = mirror_out_r;

endmodule
